/* rtl/core/msts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer scheduler package
// Item codes, result codes and sequencer states shared by the scheduler files.
// ----------------------------------------------------------------------------
package msts_pkg;

	// Width of the slot fields on the item channels
	localparam int SLOT_W = 4;
	// Width of the tolerance register
	localparam int TOL_W = 16;
	// Width of the interval field
	localparam int IVL_W = 32;

	// Request codes
	typedef enum logic [1:0] {
		FUNC_REG   = 2'd0,
		FUNC_UNREG = 2'd1,
		FUNC_TICK  = 2'd2
	} func_t;

	// Result codes
	typedef enum logic [1:0] {
		KIND_REG_ACK   = 2'd0,
		KIND_UNREG_ACK = 2'd1,
		KIND_FIRED     = 2'd2
	} kind_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACK,
		ST_INC,
		ST_THR,
		ST_SCAN,
		ST_PICK,
		ST_FIRE
	} state_t;

endpackage

/* rtl/core/msts_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
interface msts_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   func;
	logic [msts_pkg::SLOT_W-1:0]  timer_slot;
	logic [msts_pkg::IVL_W-1:0]   interval;
	logic                         one_shot;

	modport source (output valid, output func, output timer_slot, output interval,
		output one_shot, input ready);
	modport sink (input valid, input func, input timer_slot, input interval,
		input one_shot, output ready);
endinterface

/* rtl/core/msts_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface msts_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   kind;
	logic [msts_pkg::SLOT_W-1:0]  slot;
	logic                         last;

	modport source (output valid, output kind, output slot, output last, input ready);
	modport sink (input valid, input kind, input slot, input last, output ready);
endinterface

/* rtl/core/multi_slot_timer_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-slot timer scheduler
// Table of one-shot or periodic timers advanced by tick items.
// ----------------------------------------------------------------------------
// The block takes one request item at a time. A register or unregister item
// waits on the result channel when it stalls, and so does a tick item that
// fires. Every firing needs a full pass over the slot table, one slot per
// cycle through the single read port of the wake-time memory, and one
// saturating adder is shared by the time counter, threshold, registration and
// re-arm updates. Fired results leave in ascending wake order, ties to the
// lower slot, through an output register, so a result may wait while the next
// pass runs. Only slots 0 to 15 are reachable from the request channel.

module multi_slot_timer_scheduler #(
	parameter int NUM_SLOTS = 16,
	parameter int TIME_BITS = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [msts_pkg::TOL_W-1:0]  cfg_wdata,
	msts_req_if.sink                    req,
	msts_rsp_if.source                  rsp
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SUM_W = ((TIME_BITS > msts_pkg::IVL_W) ? TIME_BITS : msts_pkg::IVL_W) + 1;
	localparam int SW    = msts_pkg::SLOT_W;
	localparam logic [IDX_W:0] CNT_N = (IDX_W + 1)'(NUM_SLOTS);
	localparam logic [7:0] NSLOT_L = 8'(NUM_SLOTS);

	// Control and configuration state
	msts_pkg::state_t state_q, state_d;
	logic [msts_pkg::TOL_W-1:0] tol_q;
	logic [TIME_BITS-1:0]       now_q;
	logic [TIME_BITS-1:0]       thr_q;
	logic [NUM_SLOTS-1:0]       armed_q;
	logic [NUM_SLOTS-1:0]       due_q;
	logic                       first_q;
	logic                       found_q;
	logic [IDX_W-1:0]           best_q;
	logic [TIME_BITS-1:0]       best_wake_q;
	logic [IDX_W:0]             cnt_q;
	logic                       v_s1;
	logic [IDX_W-1:0]           idx_s1;
	msts_pkg::kind_t            ack_kind_q;
	logic [SW-1:0]              ack_slot_q;

	// Slot tables
	logic [TIME_BITS-1:0]       wake_mem [NUM_SLOTS];
	logic [msts_pkg::IVL_W-1:0] ivl_mem  [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]       os_q;
	logic [TIME_BITS-1:0]       rd_wake_q;
	logic [msts_pkg::IVL_W-1:0] rd_ivl_q;

	// Result register
	logic                       out_valid_q;
	msts_pkg::kind_t            out_kind_q;
	logic [SW-1:0]              out_slot_q;
	logic                       out_last_q;

	// Combinational control
	logic                       accept;
	logic                       out_free;
	logic                       slot_ok;
	logic [IDX_W-1:0]           req_idx;
	logic                       ack_go;
	logic                       fire_go;
	logic                       fire_last;
	logic [NUM_SLOTS-1:0]       best_oh;
	logic                       scan_issue;
	logic [IDX_W-1:0]           rd_addr;
	logic                       cand;
	logic                       better;
	logic [SUM_W-1:0]           add_b;
	logic [SUM_W-1:0]           add_sum;
	logic [TIME_BITS-1:0]       sat_sum;

	assign accept     = req.valid && req.ready;
	assign out_free   = !out_valid_q || rsp.ready;
	assign slot_ok    = ({4'd0, req.timer_slot} < NSLOT_L);
	assign req_idx    = IDX_W'(req.timer_slot);
	assign ack_go     = (state_q == msts_pkg::ST_ACK) && out_free;
	assign fire_go    = (state_q == msts_pkg::ST_FIRE) && out_free;
	assign best_oh    = NUM_SLOTS'(1) << best_q;
	assign fire_last  = ((due_q & ~best_oh) == '0);
	assign scan_issue = (state_q == msts_pkg::ST_SCAN) && (cnt_q < CNT_N);
	assign rd_addr    = (state_q == msts_pkg::ST_SCAN) ? cnt_q[IDX_W-1:0] : best_q;
	assign req.ready  = (state_q == msts_pkg::ST_IDLE);

	// Shared saturating adder: now plus interval, one, tolerance or period
	always_comb begin
		case (state_q)
			msts_pkg::ST_INC:  add_b = SUM_W'(1);
			msts_pkg::ST_THR:  add_b = SUM_W'(tol_q);
			msts_pkg::ST_FIRE: add_b = SUM_W'(rd_ivl_q);
			default:           add_b = SUM_W'(req.interval);
		endcase
		add_sum = SUM_W'(now_q) + add_b;
		sat_sum = (add_sum[SUM_W-1:TIME_BITS] != '0) ? '1 : add_sum[TIME_BITS-1:0];
	end

	// Scan compare: first pass builds the due set, later passes use it
	always_comb begin
		cand   = first_q ? (armed_q[idx_s1] && (rd_wake_q <= thr_q)) : due_q[idx_s1];
		better = v_s1 && cand && (!found_q || (rd_wake_q < best_wake_q));
	end

	// Next-state logic
	always_comb begin
		state_d = state_q;
		case (state_q)
			msts_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.func)
						msts_pkg::FUNC_REG,
						msts_pkg::FUNC_UNREG: if (slot_ok) state_d = msts_pkg::ST_ACK;
						msts_pkg::FUNC_TICK:  state_d = msts_pkg::ST_INC;
						default:              state_d = msts_pkg::ST_IDLE;
					endcase
				end
			end
			msts_pkg::ST_ACK:  if (out_free) state_d = msts_pkg::ST_IDLE;
			msts_pkg::ST_INC:  state_d = msts_pkg::ST_THR;
			msts_pkg::ST_THR:  state_d = msts_pkg::ST_SCAN;
			msts_pkg::ST_SCAN: if (!scan_issue && !v_s1) state_d = msts_pkg::ST_PICK;
			msts_pkg::ST_PICK: state_d = found_q ? msts_pkg::ST_FIRE : msts_pkg::ST_IDLE;
			msts_pkg::ST_FIRE: begin
				if (out_free) state_d = fire_last ? msts_pkg::ST_IDLE : msts_pkg::ST_SCAN;
			end
			default: state_d = msts_pkg::ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= '0;
			now_q       <= '0;
			armed_q     <= '0;
			due_q       <= '0;
			first_q     <= 1'b0;
			found_q     <= 1'b0;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) tol_q <= cfg_wdata;

			// register / unregister update the armed bits at once
			if (accept && slot_ok) begin
				if (req.func == msts_pkg::FUNC_REG)   armed_q[req_idx] <= 1'b1;
				if (req.func == msts_pkg::FUNC_UNREG) armed_q[req_idx] <= 1'b0;
			end

			if (state_q == msts_pkg::ST_INC) now_q <= sat_sum;

			// start of the first pass
			if (state_q == msts_pkg::ST_THR) begin
				first_q <= 1'b1;
				found_q <= 1'b0;
				cnt_q   <= '0;
			end

			// scan pipeline
			v_s1 <= scan_issue;
			if (scan_issue) cnt_q <= cnt_q + 1'b1;
			if (v_s1 && first_q) due_q[idx_s1] <= cand;
			if (better) found_q <= 1'b1;

			// firing retires one slot and restarts the scan
			if (fire_go) begin
				due_q[best_q] <= 1'b0;
				if (os_q[best_q]) armed_q[best_q] <= 1'b0;
				first_q <= 1'b0;
				found_q <= 1'b0;
				cnt_q   <= '0;
			end

			// result register
			if (ack_go || fire_go) out_valid_q <= 1'b1;
			else if (rsp.ready)    out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (state_q == msts_pkg::ST_THR) thr_q <= sat_sum;
		if (better) begin
			best_q      <= idx_s1;
			best_wake_q <= rd_wake_q;
		end
		if (accept) begin
			ack_kind_q <= (req.func == msts_pkg::FUNC_REG) ? msts_pkg::KIND_REG_ACK
				: msts_pkg::KIND_UNREG_ACK;
			ack_slot_q <= req.timer_slot;
		end
		if (ack_go) begin
			out_kind_q <= ack_kind_q;
			out_slot_q <= ack_slot_q;
			out_last_q <= 1'b1;
		end else if (fire_go) begin
			out_kind_q <= msts_pkg::KIND_FIRED;
			out_slot_q <= SW'(best_q);
			out_last_q <= fire_last;
		end
	end

	// Slot memories: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (accept && slot_ok && (req.func == msts_pkg::FUNC_REG)) begin
			wake_mem[req_idx] <= sat_sum;
			ivl_mem[req_idx]  <= req.interval;
			os_q[req_idx]     <= req.one_shot;
		end else if (fire_go && !os_q[best_q]) begin
			wake_mem[best_q] <= sat_sum;
		end
		rd_wake_q <= wake_mem[rd_addr];
		rd_ivl_q  <= ivl_mem[rd_addr];
	end

	assign rsp.valid = out_valid_q;
	assign rsp.kind  = out_kind_q;
	assign rsp.slot  = out_slot_q;
	assign rsp.last  = out_last_q;

`ifndef SYNTHESIS
	// a fired slot is armed up to its firing
	a_fire_armed: assert property (@(posedge clk) disable iff (!arst_n)
		fire_go |-> armed_q[best_q])
		else $error("firing slot is not armed");

	// due set never holds a disarmed slot
	a_due_subset: assert property (@(posedge clk) disable iff (!arst_n)
		(due_q & ~armed_q) == '0)
		else $error("due slot is not armed");

	// time counter never moves backward
	a_time_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> now_q >= $past(now_q))
		else $error("time counter decreased");

	// due set is empty whenever a new item can be taken
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (due_q == '0))
		else $error("due slots left after tick");
`endif

endmodule

/* tb/multi_slot_timer_scheduler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer scheduler testbench
// Drives register, unregister and tick items into the scheduler and checks
// every acknowledge and firing against a cycle-free model of the slot table.
// A short directed table comes first, then random phases at several fire
// tolerances, with random stalls on both channels and one long result stall.
// ----------------------------------------------------------------------------
module multi_slot_timer_scheduler_test;

	localparam int N_SLOTS = 16;
	localparam int TIME_W = 48;
	localparam logic [1:0] FUNC_BAD = 2'd3;
	localparam int PHASE_ITEMS = 85;
	localparam int N_PHASES = 4;
	localparam int SETTLE_CYCLES = 64;
	localparam int LONG_HOLD = 400;
	localparam int CYCLE_LIMIT = 1000000;
	// expectation modes of a directed row
	localparam int FIX_MODEL = -1;
	localparam int FIX_NONE = 0;
	localparam int FIX_ACK = 1;

	typedef logic [TIME_W-1:0] tstamp_t;
	typedef logic [msts_pkg::SLOT_W-1:0] slot_t;
	typedef logic [msts_pkg::TOL_W-1:0] tol_t;
	localparam tstamp_t T_MAX = '1;

	typedef struct packed {
		logic [1:0]                  func;
		logic [msts_pkg::SLOT_W-1:0] slot;
		logic [msts_pkg::IVL_W-1:0]  ivl;
		logic                        one_shot;
	} sched_req_t;

	typedef struct {
		sched_req_t it;
		int         fixed;
	} offered_t;

	typedef struct packed {
		msts_pkg::kind_t             kind;
		logic [msts_pkg::SLOT_W-1:0] slot;
		logic                        last;
	} sched_rsp_t;

	typedef struct {
		bit         cfg;
		logic [msts_pkg::TOL_W-1:0] tol;
		sched_req_t it;
		int         fixed;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [msts_pkg::TOL_W-1:0] cfg_wdata;

	msts_req_if req_ch();
	msts_rsp_if rsp_ch();

	multi_slot_timer_scheduler #(
		.NUM_SLOTS(N_SLOTS),
		.TIME_BITS(TIME_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Timer table model
	logic [msts_pkg::TOL_W-1:0] m_tol;
	tstamp_t          m_now;
	logic             m_armed [N_SLOTS];
	tstamp_t          m_wake [N_SLOTS];
	logic [msts_pkg::IVL_W-1:0] m_ivl [N_SLOTS];
	logic             m_once [N_SLOTS];

	sched_rsp_t step_rsp [$];
	sched_rsp_t awaited_rsp [$];
	offered_t   queued_reqs [$];
	dir_row_t   dir_tab [$];
	sched_req_t phase_plan [$];

	int  err_count = 0;
	int  cycle_count = 0;
	bit  rsp_hold_req = 1'b0;
	bit  no_idle = 1'b0;

	function automatic tstamp_t sat_sum(tstamp_t a, tstamp_t b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? T_MAX : s[TIME_W-1:0];
	endfunction

	// Apply one item to the model; results land in step_rsp
	function automatic void sched_step(sched_req_t it);
		tstamp_t     thr;
		tstamp_t     old_w [N_SLOTS];
		logic        due [N_SLOTS];
		int          best;
		sched_rsp_t  r;
		step_rsp.delete();
		case (it.func)
			msts_pkg::FUNC_REG: begin
				m_armed[it.slot] = 1'b1;
				m_ivl[it.slot] = it.ivl;
				m_once[it.slot] = it.one_shot;
				m_wake[it.slot] = sat_sum(m_now, tstamp_t'(it.ivl));
				r = '{kind: msts_pkg::KIND_REG_ACK, slot: it.slot, last: 1'b1};
				step_rsp.push_back(r);
			end
			msts_pkg::FUNC_UNREG: begin
				m_armed[it.slot] = 1'b0;
				r = '{kind: msts_pkg::KIND_UNREG_ACK, slot: it.slot, last: 1'b1};
				step_rsp.push_back(r);
			end
			msts_pkg::FUNC_TICK: begin
				m_now = sat_sum(m_now, tstamp_t'(1));
				thr = sat_sum(m_now, tstamp_t'(m_tol));
				// due set and ordering are frozen before anything fires
				for (int i = 0; i < N_SLOTS; i++) begin
					due[i] = m_armed[i] && (m_wake[i] <= thr);
					old_w[i] = m_wake[i];
				end
				for (int n = 0; n < N_SLOTS; n++) begin
					best = -1;
					for (int i = 0; i < N_SLOTS; i++)
						if (due[i] && (best < 0 || old_w[i] < old_w[best]))
							best = i;
					if (best < 0)
						break;
					due[best] = 1'b0;
					if (m_once[best])
						m_armed[best] = 1'b0;
					else
						m_wake[best] = sat_sum(m_now, tstamp_t'(m_ivl[best]));
					r = '{kind: msts_pkg::KIND_FIRED, slot: slot_t'(best), last: 1'b0};
					step_rsp.push_back(r);
				end
				if (step_rsp.size() > 0)
					step_rsp[step_rsp.size()-1].last = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// Result check and prediction at each accepted item
	always @(posedge clk) begin : monitor
		sched_rsp_t want;
		offered_t   o;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (awaited_rsp.size() == 0) begin
					$error("unexpected result: kind %0d slot %0d last %0d",
						rsp_ch.kind, rsp_ch.slot, rsp_ch.last);
					err_count++;
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp_ch.kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, rsp_ch.kind);
						err_count++;
					end
					if (rsp_ch.slot !== want.slot) begin
						$error("slot: expected %0d, actual %0d", want.slot, rsp_ch.slot);
						err_count++;
					end
					if (rsp_ch.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
						err_count++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				o = queued_reqs.pop_front();
				sched_step(o.it);
				// typed rows replace the model's results but keep its state update
				if (o.fixed == FIX_MODEL) begin
					foreach (step_rsp[i])
						awaited_rsp.push_back(step_rsp[i]);
				end else if (o.fixed == FIX_ACK) begin
					want.kind = (o.it.func == msts_pkg::FUNC_REG) ? msts_pkg::KIND_REG_ACK
						: msts_pkg::KIND_UNREG_ACK;
					want.slot = o.it.slot;
					want.last = 1'b1;
					awaited_rsp.push_back(want);
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side: random stalls, one long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (rsp_hold_req) begin
				rsp_hold_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	function automatic dir_row_t item_row(logic [1:0] f, logic [msts_pkg::SLOT_W-1:0] s,
		logic [msts_pkg::IVL_W-1:0] v, logic os, int fixed);
		dir_row_t row;
		row.cfg = 1'b0;
		row.tol = '0;
		row.it = '{func: f, slot: s, ivl: v, one_shot: os};
		row.fixed = fixed;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(logic [msts_pkg::TOL_W-1:0] tol);
		dir_row_t row;
		row = item_row(msts_pkg::FUNC_TICK, '0, '0, 1'b0, FIX_NONE);
		row.cfg = 1'b1;
		row.tol = tol;
		return row;
	endfunction

	function automatic logic [msts_pkg::IVL_W-1:0] rand_interval();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 12);
		else if (r < 85)
			return $urandom_range(0, 70000);
		return $urandom;
	endfunction

	function automatic sched_req_t rand_req();
		sched_req_t it;
		int r;
		r = $urandom_range(0, 99);
		it.slot = slot_t'($urandom_range(0, N_SLOTS - 1));
		it.one_shot = 1'($urandom_range(0, 1));
		it.ivl = rand_interval();
		if (r < 38)
			it.func = msts_pkg::FUNC_REG;
		else if (r < 50)
			it.func = msts_pkg::FUNC_UNREG;
		else if (r < 96) begin
			it.func = msts_pkg::FUNC_TICK;
			it.ivl = $urandom;   // ignored on a tick
		end else
			it.func = FUNC_BAD;
		return it;
	endfunction

	// Offer one item and wait for it to be taken
	task automatic send_req(sched_req_t it, int fixed);
		offered_t o;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		o.it = it;
		o.fixed = fixed;
		queued_reqs.push_back(o);
		req_ch.valid <= 1'b1;
		req_ch.func <= it.func;
		req_ch.timer_slot <= it.slot;
		req_ch.interval <= it.ivl;
		req_ch.one_shot <= it.one_shot;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
	endtask

	// Stop offering and let the block run dry
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (awaited_rsp.size() != 0 || queued_reqs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [msts_pkg::TOL_W-1:0] tol);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= tol;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_tol = tol;
	endtask

	// Random plan for one phase, with one full-table burst
	task automatic build_phase();
		bit burst_done;
		sched_req_t it;
		burst_done = 1'b0;
		phase_plan.delete();
		while (phase_plan.size() < PHASE_ITEMS) begin
			if (!burst_done && ($urandom_range(0, 29) == 0 ||
				phase_plan.size() >= PHASE_ITEMS - N_SLOTS - 3)) begin
				burst_done = 1'b1;
				for (int s = 0; s < N_SLOTS; s++) begin
					it.func = msts_pkg::FUNC_REG;
					it.slot = slot_t'(s);
					it.ivl = $urandom_range(0, 2);
					it.one_shot = 1'($urandom_range(0, 1));
					phase_plan.push_back(it);
				end
				repeat (3) begin
					it.func = msts_pkg::FUNC_TICK;
					it.ivl = $urandom;
					phase_plan.push_back(it);
				end
			end else
				phase_plan.push_back(rand_req());
		end
	endtask

	// Stimulus
	initial begin
		logic [msts_pkg::TOL_W-1:0] tol_plan [N_PHASES];
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.func <= msts_pkg::FUNC_REG;
		req_ch.timer_slot <= '0;
		req_ch.interval <= '0;
		req_ch.one_shot <= 1'b0;
		m_tol = '0;
		m_now = '0;
		for (int i = 0; i < N_SLOTS; i++) begin
			m_armed[i] = 1'b0;
			m_wake[i] = '0;
			m_ivl[i] = '0;
			m_once[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		dir_tab.push_back(cfg_row(16'h0000));
		dir_tab.push_back(item_row(msts_pkg::FUNC_TICK, 4'd0, 32'd0, 1'b0, FIX_NONE)); // quiet
		dir_tab.push_back(item_row(FUNC_BAD, 4'd9, 32'd1234, 1'b1, FIX_NONE)); // unknown func
		dir_tab.push_back(item_row(msts_pkg::FUNC_UNREG, 4'd5, 32'd0, 1'b0, FIX_ACK)); // idle
		dir_tab.push_back(item_row(msts_pkg::FUNC_REG, 4'd0, 32'd0, 1'b1, FIX_ACK));
		dir_tab.push_back(item_row(msts_pkg::FUNC_REG, 4'd15, 32'hFFFF_FFFF, 1'b0, FIX_ACK));
		dir_tab.push_back(item_row(msts_pkg::FUNC_TICK, 4'd0, 32'd0, 1'b0, FIX_MODEL));
		dir_tab.push_back(item_row(msts_pkg::FUNC_REG, 4'd3, 32'd2, 1'b0, FIX_ACK));
		dir_tab.push_back(item_row(msts_pkg::FUNC_REG, 4'd1, 32'd2, 1'b1, FIX_ACK)); // tie
		dir_tab.push_back(item_row(msts_pkg::FUNC_REG, 4'd7, 32'd1, 1'b0, FIX_ACK));
		dir_tab.push_back(item_row(msts_pkg::FUNC_TICK, 4'd0, 32'd0, 1'b0, FIX_MODEL));
		dir_tab.push_back(item_row(msts_pkg::FUNC_TICK, 4'd0, 32'd0, 1'b0, FIX_MODEL));
		dir_tab.push_back(item_row(msts_pkg::FUNC_REG, 4'd3, 32'd5, 1'b1, FIX_ACK)); // re-arm
		dir_tab.push_back(item_row(msts_pkg::FUNC_UNREG, 4'd7, 32'd0, 1'b0, FIX_ACK));
		// due every tick
		dir_tab.push_back(item_row(msts_pkg::FUNC_REG, 4'd2, 32'd0, 1'b0, FIX_ACK));
		dir_tab.push_back(item_row(msts_pkg::FUNC_TICK, 4'd0, 32'd0, 1'b0, FIX_MODEL));
		dir_tab.push_back(item_row(msts_pkg::FUNC_TICK, 4'd0, 32'd0, 1'b0, FIX_MODEL));
		dir_tab.push_back(cfg_row(16'hFFFF));
		dir_tab.push_back(item_row(msts_pkg::FUNC_REG, 4'd9, 32'd60000, 1'b1, FIX_ACK));
		dir_tab.push_back(item_row(msts_pkg::FUNC_TICK, 4'd0, 32'd0, 1'b0, FIX_MODEL));
		// wake lands exactly on the threshold
		dir_tab.push_back(item_row(msts_pkg::FUNC_REG, 4'd4, 32'd65536, 1'b0, FIX_ACK));
		dir_tab.push_back(item_row(msts_pkg::FUNC_TICK, 4'd0, 32'd0, 1'b0, FIX_MODEL));
		dir_tab.push_back(item_row(msts_pkg::FUNC_UNREG, 4'd2, 32'd0, 1'b0, FIX_ACK));
		dir_tab.push_back(item_row(msts_pkg::FUNC_UNREG, 4'd15, 32'd0, 1'b0, FIX_ACK));
		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg)
				write_tolerance(dir_tab[i].tol);
			else
				send_req(dir_tab[i].it, dir_tab[i].fixed);
		end

		// random phases
		tol_plan[0] = 16'h0000;
		tol_plan[1] = 16'hFFFF;
		tol_plan[2] = tol_t'($urandom_range(0, 65535));
		tol_plan[3] = tol_t'($urandom_range(1, 8));
		for (int p = 0; p < N_PHASES; p++) begin
			write_tolerance(tol_plan[p]);
			if (p == 1)
				rsp_hold_req = 1'b1;
			build_phase();
			foreach (phase_plan[k]) begin
				if (p == N_PHASES - 1 && k >= PHASE_ITEMS / 2)
					no_idle = 1'b1;
				send_req(phase_plan[k], FIX_MODEL);
			end
		end

		wait_drained();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
